@@ hdl/trsc_pkg.sv @@
`timescale 1ns / 1ps

package trsc_pkg;

	// alphabet and field widths
	localparam int ROTOR_SIZE = 28;
	localparam int IDX_W      = 5;
	localparam int SUM_W      = IDX_W + 1;
	localparam int CHAR_W     = 8;
	localparam int STATUS_W   = 3;
	localparam int OPCODE_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	// ascii codes
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [CHAR_W-1:0] CASE_GAP   = 8'd32;

	// symbol indexes of the two punctuation marks
	localparam logic [IDX_W-1:0] SYM_SPACE = 5'd26;
	localparam logic [IDX_W-1:0] SYM_DOT   = 5'd27;

	typedef enum logic [OPCODE_W-1:0] {
		OP_CODE    = 2'd0,
		OP_LOAD    = 2'd1,
		OP_RESTART = 2'd2
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_CODED   = 3'd0,
		STAT_NEWLINE = 3'd1,
		STAT_INVALID = 3'd2,
		STAT_NOMATCH = 3'd3,
		STAT_ACK     = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE         = 2'd0,
		CFG_ROTOR1_START = 2'd1,
		CFG_ROTOR2_START = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_KEY    = 2'd1,
		S_RESULT = 2'd2
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load_in;
		logic load_key;
		logic emit;
	} trsc_cmd_t;

endpackage

@@ hdl/trsc_if.sv @@
`timescale 1ns / 1ps

// request channel
interface trsc_req_if;
	logic                          valid;
	logic                          ready;
	logic [trsc_pkg::OPCODE_W-1:0] opcode;
	logic                          rotor_select;
	logic [trsc_pkg::IDX_W-1:0]    entry_index;
	logic [trsc_pkg::CHAR_W-1:0]   entry_value;
	logic [trsc_pkg::CHAR_W-1:0]   char_in;

	modport source (output valid, opcode, rotor_select, entry_index, entry_value, char_in,
		input ready);
	modport sink (input valid, opcode, rotor_select, entry_index, entry_value, char_in,
		output ready);
endinterface

// result channel
interface trsc_res_if;
	logic                          valid;
	logic                          ready;
	logic [trsc_pkg::CHAR_W-1:0]   char_out;
	logic [trsc_pkg::STATUS_W-1:0] status;

	modport source (output valid, char_out, status, input ready);
	modport sink (input valid, char_out, status, output ready);
endinterface

// configuration write channel
interface trsc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [trsc_pkg::CFG_IDX_W-1:0]  index;
	logic [trsc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/trsc_ctrl.sv @@
`timescale 1ns / 1ps

module trsc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                res_valid,
	input  logic                res_ready,
	output trsc_pkg::trsc_cmd_t cmd
);
	import trsc_pkg::*;

	state_t state_q, state_d;
	logic   res_valid_q;
	logic   slot_free;

	// output word slot can take a new word
	assign slot_free = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		req_ready    = 1'b0;
		cmd.load_in  = 1'b0;
		cmd.load_key = 1'b0;
		cmd.emit     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_KEY;
				end
			end
			S_KEY: begin
				cmd.load_key = 1'b1;
				state_d      = S_RESULT;
			end
			S_RESULT: begin
				if (slot_free) begin
					cmd.emit  = 1'b1;
					req_ready = 1'b1;
					if (req_valid) begin
						cmd.load_in = 1'b1;
						state_d     = S_KEY;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
		endcase
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	a_load_then_key: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_in |=> state_q == S_KEY)
		else $error("accepted word not followed by key read");

	a_valid_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_RESULT))
		else $error("result valid raised outside result state");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!res_valid_q || res_ready))
		else $error("pending result word overwritten");

endmodule

@@ hdl/trsc_datapath.sv @@
`timescale 1ns / 1ps

module trsc_datapath #(
	parameter int VALUE_WIDTH = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  trsc_pkg::trsc_cmd_t               cmd,
	input  logic [trsc_pkg::OPCODE_W-1:0]     opcode,
	input  logic                              rotor_select,
	input  logic [trsc_pkg::IDX_W-1:0]        entry_index,
	input  logic [trsc_pkg::CHAR_W-1:0]       entry_value,
	input  logic [trsc_pkg::CHAR_W-1:0]       char_in,
	input  logic                              cfg_we,
	input  logic [trsc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [trsc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic [trsc_pkg::CHAR_W-1:0]       char_out,
	output logic [trsc_pkg::STATUS_W-1:0]     status
);
	import trsc_pkg::*;

	localparam int EXT_W = VALUE_WIDTH + CHAR_W;

	// reduce a sum below twice the rotor size to a rotor position
	function automatic logic [IDX_W-1:0] fold(input logic [SUM_W-1:0] v);
		logic [IDX_W-1:0] r;
		if (v >= SUM_W'(ROTOR_SIZE)) begin
			r = IDX_W'(v - SUM_W'(ROTOR_SIZE));
		end else begin
			r = IDX_W'(v);
		end
		return r;
	endfunction

	logic [VALUE_WIDTH-1:0] tab1_q [ROTOR_SIZE];
	logic [VALUE_WIDTH-1:0] tab2_q [ROTOR_SIZE];
	logic [OPCODE_W-1:0]    op_q;
	logic                   sel_q;
	logic [IDX_W-1:0]       eidx_q;
	logic [CHAR_W-1:0]      eval_q;
	logic [CHAR_W-1:0]      ch_q;
	logic [VALUE_WIDTH-1:0] key_q;
	logic [IDX_W-1:0]       off1_q, off2_q;
	logic                   mode_q;
	logic [IDX_W-1:0]       start1_q, start2_q;
	logic [CHAR_W-1:0]      char_q;
	status_t                status_q;

	logic [CHAR_W-1:0]       folded;
	logic [IDX_W-1:0]        sym;
	logic                    sym_ok;
	logic [IDX_W-1:0]        key_idx1, key_idx2;
	logic [VALUE_WIDTH-1:0]  key_d;
	logic [EXT_W-1:0]        val_ext;
	logic [VALUE_WIDTH-1:0]  load_val;
	logic [ROTOR_SIZE-1:0]   hit;
	logic [2*ROTOR_SIZE-1:0] hit_dbl, hit_shift;
	logic [ROTOR_SIZE-1:0]   hit_rot;
	logic [IDX_W-1:0]        shift_amt;
	logic                    found;
	logic [IDX_W-1:0]        pos;
	logic [CHAR_W-1:0]       pos_char;
	logic [CHAR_W-1:0]       res_char;
	status_t                 res_status;
	logic                    advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			start1_q <= '0;
			start2_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_MODE:         mode_q   <= cfg_data[0];
				CFG_ROTOR1_START: start1_q <= cfg_data;
				CFG_ROTOR2_START: start2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input word register
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q   <= opcode;
			sel_q  <= rotor_select;
			eidx_q <= entry_index;
			eval_q <= entry_value;
			ch_q   <= char_in;
		end
	end

	// character to symbol index, lowercase folded
	always_comb begin
		folded = ch_q;
		if (ch_q >= CH_LOWER_A && ch_q <= CH_LOWER_Z) begin
			folded = ch_q - CASE_GAP;
		end
		sym    = '0;
		sym_ok = 1'b1;
		if (folded == CH_SPACE) begin
			sym = SYM_SPACE;
		end else if (folded == CH_DOT) begin
			sym = SYM_DOT;
		end else if (folded >= CH_UPPER_A && folded <= CH_UPPER_Z) begin
			sym = IDX_W'(folded - CH_UPPER_A);
		end else begin
			sym_ok = 1'b0;
		end
	end

	// key read from the forward rotor at the turned position
	assign key_idx1 = fold({1'b0, sym} + SUM_W'(ROTOR_SIZE) - {1'b0, off1_q});
	assign key_idx2 = fold({1'b0, sym} + {1'b0, off2_q});
	assign key_d    = mode_q ? tab2_q[key_idx2] : tab1_q[key_idx1];

	always_ff @(posedge clk) begin
		if (cmd.load_key) begin
			key_q <= key_d;
		end
	end

	// compare key against every entry of the search rotor
	always_comb begin
		for (int k = 0; k < ROTOR_SIZE; k++) begin
			hit[k] = (mode_q ? tab1_q[k] : tab2_q[k]) == key_q;
		end
	end

	// turn the hit vector into rotor position order
	always_comb begin
		if (mode_q) begin
			shift_amt = (off1_q == '0) ? '0 : IDX_W'(ROTOR_SIZE) - off1_q;
		end else begin
			shift_amt = off2_q;
		end
		hit_dbl   = {hit, hit};
		hit_shift = hit_dbl >> shift_amt;
		hit_rot   = hit_shift[ROTOR_SIZE-1:0];
	end

	// first matching position
	always_comb begin
		found = |hit_rot;
		pos   = '0;
		for (int j = ROTOR_SIZE - 1; j >= 0; j--) begin
			if (hit_rot[j]) begin
				pos = IDX_W'(j);
			end
		end
		if (pos == SYM_SPACE) begin
			pos_char = CH_SPACE;
		end else if (pos == SYM_DOT) begin
			pos_char = CH_DOT;
		end else begin
			pos_char = CH_UPPER_A + CHAR_W'(pos);
		end
	end

	// result word and rotor turn
	always_comb begin
		res_char   = '0;
		res_status = STAT_ACK;
		advance    = 1'b0;
		unique case (op_q)
			OP_CODE: begin
				if (ch_q == CH_NEWLINE) begin
					res_char   = ch_q;
					res_status = STAT_NEWLINE;
				end else if (!sym_ok) begin
					res_char   = ch_q;
					res_status = STAT_INVALID;
				end else begin
					advance = 1'b1;
					if (found) begin
						res_char   = pos_char;
						res_status = STAT_CODED;
					end else begin
						res_status = STAT_NOMATCH;
					end
				end
			end
			default: ;
		endcase
	end

	// rotor offsets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off1_q <= '0;
			off2_q <= '0;
		end else if (cmd.emit) begin
			if (op_q == OP_RESTART) begin
				off1_q <= fold({1'b0, start1_q});
				off2_q <= fold({1'b0, start2_q});
			end else if (advance) begin
				off1_q <= fold({1'b0, off1_q} + SUM_W'(1));
				off2_q <= fold({1'b0, off2_q} + SUM_W'(1));
			end
		end
	end

	// rotor table load
	assign val_ext  = {{VALUE_WIDTH{1'b0}}, eval_q};
	assign load_val = val_ext[VALUE_WIDTH-1:0];

	always_ff @(posedge clk) begin
		if (cmd.emit && op_q == OP_LOAD && eidx_q < IDX_W'(ROTOR_SIZE)) begin
			if (sel_q) begin
				tab2_q[eidx_q] <= load_val;
			end else begin
				tab1_q[eidx_q] <= load_val;
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			char_q   <= res_char;
			status_q <= res_status;
		end
	end

	assign char_out = char_q;
	assign status   = status_q;

	a_off_range: assert property (@(posedge clk) disable iff (!arst_n)
		off1_q < IDX_W'(ROTOR_SIZE) && off2_q < IDX_W'(ROTOR_SIZE))
		else $error("rotor offset out of range");

	a_turn_on_code: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && advance |=> off1_q != $past(off1_q) && off2_q != $past(off2_q))
		else $error("rotors did not turn after a coded character");

	a_hold_offsets: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.emit |=> $stable(off1_q) && $stable(off2_q))
		else $error("rotor offsets changed without a result");

endmodule

@@ hdl/two_rotor_substitution_cipher.sv @@
// steps: the request word is registered, the key is read from the forward rotor into
// the key register, then the 28-way compare against the other rotor gives the result
//   word, which is written to the output register when the output slot is free
// a stalled result holds the block; the next request is taken as a result is written
// reset clears control, offsets and configuration; rotor tables must be loaded first
`timescale 1ns / 1ps

module two_rotor_substitution_cipher #(
	parameter int VALUE_WIDTH = 8
) (
	input logic       clk,
	input logic       arst_n,
	trsc_req_if.sink  request,
	trsc_res_if.source result,
	trsc_cfg_if.sink  cfg
);
	import trsc_pkg::*;

	trsc_cmd_t cmd;

	// configuration writes are always taken
	assign cfg.ready = 1'b1;

	// controller
	trsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_ready (request.ready),
		.res_valid (result.valid),
		.res_ready (result.ready),
		.cmd       (cmd)
	);

	// datapath
	trsc_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.opcode       (request.opcode),
		.rotor_select (request.rotor_select),
		.entry_index  (request.entry_index),
		.entry_value  (request.entry_value),
		.char_in      (request.char_in),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.char_out     (result.char_out),
		.status       (result.status)
	);

endmodule

@@ tb/trsc_cipher_check.sv @@
`timescale 1ns / 1ps

module trsc_cipher_check #(
	parameter int VALUE_WIDTH = 8
) (
	input logic clk,
	input logic arst_n,
	trsc_req_if request,
	trsc_res_if result,
	trsc_cfg_if cfg,
	output int  fail_count,
	output int  outstanding
);
	import trsc_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] char_out;
		status_t           status;
	} cipher_word_t;

	// rotor tables as loaded, turning is kept in the offsets
	logic [VALUE_WIDTH-1:0] first_rotor[ROTOR_SIZE];
	logic [VALUE_WIDTH-1:0] second_rotor[ROTOR_SIZE];
	logic [IDX_W-1:0]       first_turn;
	logic [IDX_W-1:0]       second_turn;
	logic                   decrypt;
	logic [IDX_W-1:0]       first_start;
	logic [IDX_W-1:0]       second_start;
	cipher_word_t           coded_words[$];
	int                     mismatches = 0;

	task automatic report_mismatch(input string what);
		// keep the log short when the block is badly off
		if (mismatches < 100)
			$display("%t: mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic logic [VALUE_WIDTH-1:0] first_at(input int pos);
		return first_rotor[(pos + ROTOR_SIZE - first_turn) % ROTOR_SIZE];
	endfunction

	function automatic logic [VALUE_WIDTH-1:0] second_at(input int pos);
		return second_rotor[(pos + second_turn) % ROTOR_SIZE];
	endfunction

	// alphabet position of a character, lowercase folded; -1 when outside
	function automatic int symbol_of(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] up;
		up = (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - CASE_GAP : c;
		if (up == CH_SPACE)
			return SYM_SPACE;
		if (up == CH_DOT)
			return SYM_DOT;
		if (up >= CH_UPPER_A && up <= CH_UPPER_Z)
			return up - CH_UPPER_A;
		return -1;
	endfunction

	function automatic logic [CHAR_W-1:0] char_of(input int sym);
		if (sym == SYM_SPACE)
			return CH_SPACE;
		if (sym == SYM_DOT)
			return CH_DOT;
		return CH_UPPER_A + CHAR_W'(sym);
	endfunction

	// one request word: update rotor state and return the word it produces
	function automatic cipher_word_t cipher_step(input logic [OPCODE_W-1:0] op,
			input logic sel, input logic [IDX_W-1:0] idx,
			input logic [CHAR_W-1:0] value, input logic [CHAR_W-1:0] ch);
		cipher_word_t           w;
		int                     sym;
		int                     hit;
		int                     j;
		logic [VALUE_WIDTH-1:0] key;
		logic [VALUE_WIDTH-1:0] probe;
		w.char_out = '0;
		w.status   = STAT_ACK;
		case (op)
		OP_LOAD: begin
			if (idx < ROTOR_SIZE) begin
				if (sel)
					second_rotor[idx] = VALUE_WIDTH'(value);
				else
					first_rotor[idx] = VALUE_WIDTH'(value);
			end
		end
		OP_RESTART: begin
			first_turn  = IDX_W'(first_start % ROTOR_SIZE);
			second_turn = IDX_W'(second_start % ROTOR_SIZE);
		end
		OP_CODE: begin
			sym = symbol_of(ch);
			if (ch == CH_NEWLINE) begin
				w.char_out = ch;
				w.status   = STAT_NEWLINE;
			end else if (sym < 0) begin
				w.char_out = ch;
				w.status   = STAT_INVALID;
			end else begin
				// forward rotor gives the key, first holder in the other rotor wins
				key = decrypt ? second_at(sym) : first_at(sym);
				hit = -1;
				for (j = 0; j < ROTOR_SIZE; j++) begin
					probe = decrypt ? first_at(j) : second_at(j);
					if (hit < 0 && probe == key)
						hit = j;
				end
				if (hit >= 0) begin
					w.char_out = char_of(hit);
					w.status   = STAT_CODED;
				end else begin
					w.status = STAT_NOMATCH;
				end
				first_turn  = IDX_W'((first_turn + 1) % ROTOR_SIZE);
				second_turn = IDX_W'((second_turn + 1) % ROTOR_SIZE);
			end
		end
		default: ;
		endcase
		return w;
	endfunction

	// watch the three channels, results first so a word leaves before the next enters
	always @(posedge clk or negedge arst_n) begin
		cipher_word_t want;
		if (!arst_n) begin
			first_turn   = '0;
			second_turn  = '0;
			decrypt      = 1'b0;
			first_start  = '0;
			second_start = '0;
			coded_words.delete();
		end else begin
			if (result.valid && result.ready) begin
				if (coded_words.size() == 0) begin
					report_mismatch($sformatf("result word char_out %h status %0d with none pending",
						result.char_out, result.status));
				end else begin
					want = coded_words.pop_front();
					if (result.char_out !== want.char_out)
						report_mismatch($sformatf("char_out %h, predicted %h",
							result.char_out, want.char_out));
					if (result.status !== want.status)
						report_mismatch($sformatf("status %0d, predicted %0d",
							result.status, want.status));
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
				CFG_MODE:         decrypt = cfg.data[0];
				CFG_ROTOR1_START: first_start = cfg.data;
				CFG_ROTOR2_START: second_start = cfg.data;
				default: ;
				endcase
			end
			if (request.valid && request.ready)
				coded_words.push_back(cipher_step(request.opcode, request.rotor_select,
					request.entry_index, request.entry_value, request.char_in));
		end
		fail_count  <= mismatches;
		outstanding <= coded_words.size();
	end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import trsc_pkg::*;

	localparam int VALUE_WIDTH    = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int PHASES         = 8;
	localparam int BATCH_WORDS    = 75;
	localparam int HOLD_CYCLES    = 80;

	localparam logic [OPCODE_W-1:0]  OP_UNUSED  = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic clk;
	logic arst_n;

	trsc_req_if request();
	trsc_res_if result();
	trsc_cfg_if cfg();

	int   fail_count;
	int   outstanding;
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	logic hold_off       = 1'b0;
	int   quiet_cycles   = 0;

	// what the rotor tables hold now, so swaps keep them consistent
	logic [CHAR_W-1:0] rotor_vals[2][ROTOR_SIZE];
	int                value_mult;
	int                value_add;

	// phase plan for the registers, -1 picks a random value
	int plan_mode[PHASES]   = '{0, 1, 22, 1, -1, 31, -1, 0};
	int plan_start1[PHASES] = '{0, 27, 31, 0, -1, 28, -1, 14};
	int plan_start2[PHASES] = '{0, 27, 28, 13, -1, 0, -1, 31};
	int plan_idle[4]        = '{0, 54, 0, 33};
	int plan_stall[4]       = '{0, 0, 54, 33};

	two_rotor_substitution_cipher #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request),
		.result (result),
		.cfg    (cfg)
	);

	trsc_cipher_check #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.request    (request),
		.result     (result),
		.cfg        (cfg),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: random stalls, or a long hold-off when asked
	initial begin
		result.ready = 1'b0;
		forever begin
			@(posedge clk);
			result.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// end the run when no word moves on any channel for too long
	always @(posedge clk) begin
		if ((request.valid && request.ready) || (result.valid && result.ready) ||
				(cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("two_rotor_substitution_cipher test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// offer one request word, with random idle cycles before it
	task automatic send_word(input logic [OPCODE_W-1:0] op, input logic sel,
			input logic [IDX_W-1:0] idx, input logic [CHAR_W-1:0] value,
			input logic [CHAR_W-1:0] ch);
		while ($urandom_range(99) < send_idle_pct) begin
			request.valid <= 1'b0;
			@(posedge clk);
		end
		request.valid        <= 1'b1;
		request.opcode       <= op;
		request.rotor_select <= sel;
		request.entry_index  <= idx;
		request.entry_value  <= value;
		request.char_in      <= ch;
		@(posedge clk);
		while (!request.ready)
			@(posedge clk);
	endtask

	// unused fields carry random noise
	task automatic send_code(input logic [CHAR_W-1:0] ch);
		send_word(OP_CODE, 1'($urandom_range(1)), IDX_W'($urandom_range(31)),
			CHAR_W'($urandom_range(255)), ch);
	endtask

	task automatic send_load(input logic sel, input logic [IDX_W-1:0] idx,
			input logic [CHAR_W-1:0] value);
		send_word(OP_LOAD, sel, idx, value, CHAR_W'($urandom_range(255)));
	endtask

	task automatic send_other(input logic [OPCODE_W-1:0] op);
		send_word(op, 1'($urandom_range(1)), IDX_W'($urandom_range(31)),
			CHAR_W'($urandom_range(255)), CHAR_W'($urandom_range(255)));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
	endtask

	// stop offering, wait for every pending result, then let the pipe settle
	task automatic drain_results();
		request.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// load all 56 entries: a shared value set in two shuffles, or small random values
	task automatic load_rotors(input bit sparse);
		int perm[ROTOR_SIZE];
		int s;
		int i;
		int j;
		int tmp;
		value_mult = 2 * $urandom_range(127) + 1;
		value_add  = $urandom_range(255);
		for (s = 0; s < 2; s++) begin
			for (i = 0; i < ROTOR_SIZE; i++)
				perm[i] = i;
			for (i = ROTOR_SIZE - 1; i > 0; i--) begin
				j       = $urandom_range(i);
				tmp     = perm[i];
				perm[i] = perm[j];
				perm[j] = tmp;
			end
			for (i = 0; i < ROTOR_SIZE; i++) begin
				rotor_vals[s][i] = sparse ? CHAR_W'($urandom_range(31)) :
					CHAR_W'(perm[i] * value_mult + value_add);
				send_load(1'(s), IDX_W'(i), rotor_vals[s][i]);
			end
		end
	endtask

	function automatic logic [CHAR_W-1:0] random_char();
		int pick;
		pick = $urandom_range(99);
		if (pick < 40)
			return CH_UPPER_A + CHAR_W'($urandom_range(25));
		if (pick < 60)
			return CH_LOWER_A + CHAR_W'($urandom_range(25));
		if (pick < 70)
			return CH_SPACE;
		if (pick < 78)
			return CH_DOT;
		if (pick < 84)
			return CH_NEWLINE;
		return CHAR_W'($urandom_range(255));
	endfunction

	function automatic int plan_value(input int v);
		return (v < 0) ? $urandom_range(31) : v;
	endfunction

	// mostly restart-and-text sequences, with table edits and noise mixed in
	task automatic run_batch(input int count);
		int                sent;
		int                pick;
		int                len;
		int                k;
		int                s;
		int                a;
		int                b;
		logic [CHAR_W-1:0] tmp;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				if ($urandom_range(3) == 0) begin
					send_other(OP_RESTART);
					sent++;
				end
				len = $urandom_range(10, 1);
				for (k = 0; k < len; k++)
					send_code(random_char());
				sent += len;
			end else if (pick < 65) begin
				send_other(OP_RESTART);
				sent++;
			end else if (pick < 75) begin
				s   = $urandom_range(1);
				a   = $urandom_range(ROTOR_SIZE - 1);
				b   = $urandom_range(ROTOR_SIZE - 1);
				tmp = rotor_vals[s][a];
				rotor_vals[s][a] = rotor_vals[s][b];
				rotor_vals[s][b] = tmp;
				send_load(1'(s), IDX_W'(a), rotor_vals[s][a]);
				send_load(1'(s), IDX_W'(b), rotor_vals[s][b]);
				sent += 2;
			end else if (pick < 80) begin
				s = $urandom_range(1);
				a = $urandom_range(ROTOR_SIZE - 1);
				rotor_vals[s][a] = CHAR_W'($urandom_range(255));
				send_load(1'(s), IDX_W'(a), rotor_vals[s][a]);
				sent++;
			end else if (pick < 85) begin
				send_load(1'($urandom_range(1)), IDX_W'($urandom_range(31, ROTOR_SIZE)),
					CHAR_W'($urandom_range(255)));
				sent++;
			end else if (pick < 88) begin
				send_other(OP_UNUSED);
				sent++;
			end else begin
				send_code($urandom_range(1) ? CH_NEWLINE : CHAR_W'($urandom_range(255)));
				sent++;
			end
		end
	endtask

	initial begin
		int phase;
		arst_n               = 1'b0;
		request.valid        = 1'b0;
		request.opcode       = OP_CODE;
		request.rotor_select = 1'b0;
		request.entry_index  = '0;
		request.entry_value  = '0;
		request.char_in      = '0;
		cfg.valid            = 1'b0;
		cfg.index            = CFG_MODE;
		cfg.data             = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// words that read no rotor entry, legal before the tables are loaded
		send_code(CH_NEWLINE);
		send_code(8'h00);
		send_code(8'hFF);
		send_code(CH_UPPER_A - 8'd1);
		send_code(CH_LOWER_Z + 8'd1);
		send_other(OP_UNUSED);
		send_other(OP_RESTART);
		send_load(1'b1, 5'd31, 8'hA5);
		load_rotors(1'b0);

		// alphabet extremes in both cases, punctuation, a high byte
		send_code(CH_UPPER_A);
		send_code(CH_UPPER_Z);
		send_code(CH_LOWER_A);
		send_code(CH_LOWER_Z);
		send_code(CH_SPACE);
		send_code(CH_DOT);
		send_code(8'h80);

		// first rotor entry outside the second rotor's value set gives no match
		send_other(OP_RESTART);
		send_load(1'b0, '0, CHAR_W'(ROTOR_SIZE * value_mult + value_add));
		send_code(CH_UPPER_A);
		send_load(1'b0, '0, rotor_vals[0][0]);

		for (phase = 0; phase < PHASES; phase++) begin
			drain_results();
			write_reg(CFG_MODE, CFG_DATA_W'(plan_value(plan_mode[phase])));
			write_reg(CFG_ROTOR1_START, CFG_DATA_W'(plan_value(plan_start1[phase])));
			write_reg(CFG_ROTOR2_START, CFG_DATA_W'(plan_value(plan_start2[phase])));
			if (phase == 4)
				write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(31)));
			cfg.valid <= 1'b0;
			send_idle_pct  = plan_idle[phase % 4];
			recv_stall_pct <= plan_stall[phase % 4];
			if (phase == 3)
				load_rotors(1'b1);
			else if (phase % 2 == 0 && phase > 0)
				load_rotors(1'b0);
			if (phase == 0) begin
				// receiver holds off while the sender keeps offering
				fork
					begin
						hold_off <= 1'b1;
						repeat (HOLD_CYCLES) @(posedge clk);
						hold_off <= 1'b0;
					end
					run_batch(BATCH_WORDS);
				join
			end else begin
				run_batch(BATCH_WORDS);
			end
		end

		drain_results();
		if (fail_count == 0 && outstanding == 0)
			$display("two_rotor_substitution_cipher test passed");
		else
			$display("two_rotor_substitution_cipher test failed");
		$finish;
	end

endmodule
